[hdl/gcode_move_segment_tracker_assert.svh]
// Assertion macros for the motion segment tracker checkers.
// Depends on nothing; taken in by the checker file.
`ifndef GCODE_MOVE_SEGMENT_TRACKER_ASSERT_SVH
`define GCODE_MOVE_SEGMENT_TRACKER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define GMST_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("gmst: assertion failed");

// next-cycle implication, disabled during reset
`define GMST_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("gmst: assertion failed");

`endif

[hdl/gmst_pkg.sv]
// Shared types, codes, reset constants and saturation helpers of the
// motion segment tracker. No dependencies.
`timescale 1ns / 1ps

package gmst_pkg;

	localparam int NUM_AXES   = 4;
	localparam int COORD_BITS = 32;
	localparam int EPS_BITS   = 16;
	localparam int NUM_BED    = 6;
	localparam int IDX_BITS   = 3;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [COORD_BITS+1:0] wide_t;

	typedef enum logic [2:0] {
		FN_MOVE   = 3'd0,
		FN_ABS    = 3'd1,
		FN_REL    = 3'd2,
		FN_SETPOS = 3'd3,
		FN_QUERY  = 3'd4
	} func_e;

	typedef enum logic [IDX_BITS-1:0] {
		REG_EPS      = 3'd0,
		REG_BED_XMIN = 3'd1,
		REG_BED_XMAX = 3'd2,
		REG_BED_YMIN = 3'd3,
		REG_BED_YMAX = 3'd4,
		REG_BED_ZMIN = 3'd5,
		REG_BED_ZMAX = 3'd6
	} reg_idx_e;

	localparam int AX_X = 0;
	localparam int AX_Y = 1;
	localparam int AX_Z = 2;
	localparam int AX_E = 3;

	localparam logic [EPS_BITS-1:0] EPS_RESET     = 16'd1;
	localparam coord_t              BED_MIN_RESET = 32'sd0;
	localparam coord_t              BED_MAX_RESET = 32'sd200000;

	localparam wide_t SAT_HI = wide_t'({3'b000, {(COORD_BITS-1){1'b1}}});
	localparam wide_t SAT_LO = ~SAT_HI;

	typedef struct packed {
		logic [2:0]                  func;
		logic [NUM_AXES-1:0]         axis_mask;
		coord_t [NUM_AXES-1:0]       val;
	} cmd_t;

	typedef struct packed {
		logic                        emitted;
		coord_t [2:0]                seg_start;
		coord_t [2:0]                seg_end;
		logic                        box_valid;
	} res_t;

	typedef struct packed {
		logic [EPS_BITS-1:0]         eps;
		coord_t [NUM_BED-1:0]        bed;
	} cfg_t;

	typedef struct packed {
		logic                        en;
		logic [IDX_BITS-1:0]         idx;
		coord_t                      value;
	} box_load_t;

	function automatic wide_t widen(coord_t c);
		return wide_t'({{2{c[COORD_BITS-1]}}, c});
	endfunction

	function automatic coord_t sat(wide_t v);
		if (v > SAT_HI) begin
			return SAT_HI[COORD_BITS-1:0];
		end
		if (v < SAT_LO) begin
			return SAT_LO[COORD_BITS-1:0];
		end
		return v[COORD_BITS-1:0];
	endfunction

endpackage

[hdl/gmst_if.sv]
// Valid/ready channel interfaces for commands and results of the tracker.
// Depends on gmst_pkg.
`timescale 1ns / 1ps

interface gmst_cmd_if;
	import gmst_pkg::*;
	logic                valid;
	logic                ready;
	logic [2:0]          func;
	logic [NUM_AXES-1:0] axis_mask;
	coord_t              val_x;
	coord_t              val_y;
	coord_t              val_z;
	coord_t              val_e;

	modport source (output valid, func, axis_mask, val_x, val_y, val_z, val_e,
		input ready);
	modport sink (input valid, func, axis_mask, val_x, val_y, val_z, val_e,
		output ready);
endinterface

interface gmst_res_if;
	import gmst_pkg::*;
	logic   valid;
	logic   ready;
	logic   emitted;
	coord_t start_x;
	coord_t start_y;
	coord_t start_z;
	coord_t end_x;
	coord_t end_y;
	coord_t end_z;
	logic   box_valid;

	modport source (output valid, emitted, start_x, start_y, start_z,
		end_x, end_y, end_z, box_valid, input ready);
	modport sink (input valid, emitted, start_x, start_y, start_z,
		end_x, end_y, end_z, box_valid, output ready);
endinterface

[hdl/gmst_cfg_regs.sv]
// Configuration register file: eps and the six bed limits, with the
// matching part-box reload strobe. Depends on gmst_pkg.
`timescale 1ns / 1ps

module gmst_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [gmst_pkg::IDX_BITS-1:0]      wr_index,
	input  logic [gmst_pkg::COORD_BITS-1:0]    wr_data,
	output gmst_pkg::cfg_t                     cfg,
	output gmst_pkg::box_load_t                box_load
);
	import gmst_pkg::*;

	logic [EPS_BITS-1:0]  eps_q;
	coord_t [NUM_BED-1:0] bed_q;
	logic                 bed_hit;

	always_comb begin
		case (wr_index)
			REG_BED_XMIN, REG_BED_XMAX, REG_BED_YMIN,
			REG_BED_YMAX, REG_BED_ZMIN, REG_BED_ZMAX: bed_hit = 1'b1;
			default: bed_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
			for (int k = 0; k < NUM_BED; k++) begin
				bed_q[k] <= (k % 2 == 0) ? BED_MIN_RESET : BED_MAX_RESET;
			end
		end else if (wr_en) begin
			if (wr_index == REG_EPS) begin
				eps_q <= wr_data[EPS_BITS-1:0];
			end else if (bed_hit) begin
				bed_q[wr_index - IDX_BITS'(1)] <= coord_t'(wr_data);
			end
		end
	end

	assign cfg.eps = eps_q;
	assign cfg.bed = bed_q;

	assign box_load.en    = wr_en && bed_hit;
	assign box_load.idx   = wr_index - IDX_BITS'(1);
	assign box_load.value = coord_t'(wr_data);

endmodule

[hdl/gmst_core.sv]
// Tracker state (position, offsets, mode, part box) and the single-pass
// command logic between the input and result registers. Depends on gmst_pkg.
`timescale 1ns / 1ps

module gmst_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  gmst_pkg::cmd_t      cmd,
	input  gmst_pkg::cfg_t      cfg,
	input  gmst_pkg::box_load_t box_load,
	output gmst_pkg::res_t      res
);
	import gmst_pkg::*;

	coord_t [NUM_AXES-1:0] pos_q;
	coord_t [NUM_AXES-1:0] off_q;
	logic                  rel_q;
	coord_t [NUM_BED-1:0]  box_q;

	coord_t [NUM_AXES-1:0] pos_d;
	coord_t [NUM_AXES-1:0] off_d;
	logic                  rel_d;
	coord_t [NUM_BED-1:0]  box_d;

	always_comb begin
		coord_t [NUM_AXES-1:0] tgt;
		wide_t  [NUM_AXES-1:0] diff;
		wide_t                 mag;
		wide_t                 eps_w;
		logic                  moved;
		logic                  emit;

		pos_d = pos_q;
		off_d = off_q;
		rel_d = rel_q;
		box_d = box_q;
		res   = '0;
		moved = 1'b0;
		eps_w = wide_t'({{(COORD_BITS+2-EPS_BITS){1'b0}}, cfg.eps});

		for (int a = 0; a < NUM_AXES; a++) begin
			if (cmd.axis_mask[a]) begin
				tgt[a] = rel_q ? sat(widen(cmd.val[a]) + widen(pos_q[a])) : cmd.val[a];
			end else begin
				tgt[a] = pos_q[a];
			end
			diff[a] = widen(tgt[a]) - widen(pos_q[a]);
		end
		for (int a = 0; a < 3; a++) begin
			mag = diff[a][COORD_BITS+1] ? -diff[a] : diff[a];
			if (mag >= eps_w) begin
				moved = 1'b1;
			end
		end
		emit = moved && (diff[AX_E] > eps_w);

		case (cmd.func)
			FN_MOVE: begin
				pos_d = tgt;
				if (emit) begin
					res.emitted = 1'b1;
					for (int a = 0; a < 3; a++) begin
						if (tgt[a] >= cfg.bed[2*a] && tgt[a] < box_q[2*a]) begin
							box_d[2*a] = tgt[a];
						end
						if (tgt[a] <= cfg.bed[2*a+1] && tgt[a] > box_q[2*a+1]) begin
							box_d[2*a+1] = tgt[a];
						end
						res.seg_start[a] = sat(widen(tgt[a]) + widen(off_q[a]));
						res.seg_end[a]   = sat(widen(pos_q[a]) + widen(off_q[a]));
					end
				end
			end
			FN_ABS: begin
				rel_d = 1'b0;
			end
			FN_REL: begin
				rel_d = 1'b1;
			end
			FN_SETPOS: begin
				for (int a = 0; a < NUM_AXES; a++) begin
					if (cmd.axis_mask[a]) begin
						off_d[a] = sat(widen(off_q[a]) + widen(pos_q[a]) - widen(cmd.val[a]));
						pos_d[a] = cmd.val[a];
					end
				end
			end
			FN_QUERY: begin
				for (int a = 0; a < 3; a++) begin
					res.seg_start[a] = box_q[2*a];
					res.seg_end[a]   = box_q[2*a+1];
				end
			end
			default: begin
			end
		endcase

		res.box_valid = 1'b1;
		for (int a = 0; a < 3; a++) begin
			if (!(box_d[2*a] < cfg.bed[2*a+1]) || !(box_d[2*a+1] > cfg.bed[2*a])) begin
				res.box_valid = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			off_q <= '0;
			rel_q <= 1'b0;
			for (int k = 0; k < NUM_BED; k++) begin
				box_q[k] <= (k % 2 == 0) ? BED_MAX_RESET : BED_MIN_RESET;
			end
		end else if (box_load.en) begin
			box_q[box_load.idx ^ IDX_BITS'(1)] <= box_load.value;
		end else if (step) begin
			pos_q <= pos_d;
			off_q <= off_d;
			rel_q <= rel_d;
			box_q <= box_d;
		end
	end

endmodule

[hdl/gcode_move_segment_tracker.sv]
// Top level of the motion segment tracker: input register, core and
// result register. Depends on gmst_pkg, gmst_if, gmst_cfg_regs, gmst_core.
//
// Usage:
//   cmd  - valid/ready channel of pre-parsed commands (func, axis_mask,
//          val_x/y/z/e). A transaction completes when valid and ready are high.
//   res  - valid/ready channel, exactly one result per command.
//   wr_en/wr_index/wr_data - register write port, taken on any edge with
//          wr_en high; write only while no command is in flight.
// Path: an accepted command goes into the input register, then into the
//   result register when that is free, and from there onto res.
// Throughput: one command per cycle while res is not held; the core updates
//   all state as a command moves from the input to the result register.
// Reset: arst_n clears the valid flags of both registers, zeroes position
//   and offsets, selects absolute mode and loads the part box with the
//   swapped bed limits. No clearing pass is needed.
// Stall: while res is held, the result register keeps its value; if the input
//   register is empty it takes one more command, then cmd.ready drops.
`timescale 1ns / 1ps

module gcode_move_segment_tracker (
	input  logic                               clk,
	input  logic                               arst_n,
	gmst_cmd_if.sink                           cmd,
	gmst_res_if.source                         res,
	input  logic                               wr_en,
	input  logic [gmst_pkg::IDX_BITS-1:0]      wr_index,
	input  logic [gmst_pkg::COORD_BITS-1:0]    wr_data
);
	import gmst_pkg::*;

	cmd_t      cmd_s1;
	logic      cmd_valid_s1;
	res_t      res_s2;
	logic      res_valid_s2;
	res_t      res_comb;
	cfg_t      cfg;
	box_load_t box_load;
	logic      advance;

	assign advance   = cmd_valid_s1 && (!res_valid_s2 || res.ready);
	assign cmd.ready = !cmd_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			cmd_valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1.func      <= cmd.func;
			cmd_s1.axis_mask <= cmd.axis_mask;
			cmd_s1.val       <= {cmd.val_e, cmd.val_z, cmd.val_y, cmd.val_x};
		end
	end

	gmst_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg),
		.box_load (box_load)
	);

	gmst_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.cmd      (cmd_s1),
		.cfg      (cfg),
		.box_load (box_load),
		.res      (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= 1'b1;
		end else if (res.ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign res.valid     = res_valid_s2;
	assign res.emitted   = res_s2.emitted;
	assign res.start_x   = res_s2.seg_start[AX_X];
	assign res.start_y   = res_s2.seg_start[AX_Y];
	assign res.start_z   = res_s2.seg_start[AX_Z];
	assign res.end_x     = res_s2.seg_end[AX_X];
	assign res.end_y     = res_s2.seg_end[AX_Y];
	assign res.end_z     = res_s2.seg_end[AX_Z];
	assign res.box_valid = res_s2.box_valid;

endmodule

[hdl/gmst_checker.sv]
// Port-level checker for the motion segment tracker and its bind.
// Depends on gmst_pkg and gcode_move_segment_tracker_assert.svh.
`timescale 1ns / 1ps
`include "gcode_move_segment_tracker_assert.svh"

module gmst_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            cmd_valid,
	input logic                            cmd_ready,
	input logic                            res_valid,
	input logic                            res_ready,
	input logic                            res_emitted,
	input logic [gmst_pkg::COORD_BITS-1:0] res_start_x
);
	import gmst_pkg::*;

	`GMST_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid)
	`GMST_ASSERT_NXT(a_res_stable, clk, arst_n, res_valid && !res_ready,
		$stable(res_emitted) && $stable(res_start_x))
	`GMST_ASSERT_IMP(a_ready_when_empty, clk, arst_n, !res_valid, cmd_ready)
	`GMST_ASSERT_IMP(a_two_cycle_latency, clk, arst_n,
		cmd_valid && cmd_ready && !res_valid, ##2 res_valid)

endmodule

bind gcode_move_segment_tracker gmst_checker u_gmst_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd.valid),
	.cmd_ready   (cmd.ready),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.res_emitted (res.emitted),
	.res_start_x (res.start_x)
);

[sim/tb_gcode_move_segment_tracker.sv]
// Self-checking testbench for gcode_move_segment_tracker: directed and random motion commands
// with random bursts, gaps and result stalls, checked against an in-bench position tracker.
// Depends on gmst_pkg, gmst_if and the tracker RTL.
`timescale 1ns / 1ps

module tb_gcode_move_segment_tracker;
	import gmst_pkg::*;

	localparam int     TIMEOUT_NS = 2_000_000;
	localparam int     LONG_HOLD  = 80;
	localparam coord_t C_MAX      = 32'sh7FFF_FFFF;
	localparam coord_t C_MIN      = 32'sh8000_0000;

	localparam logic [2:0]          FN_UNUSED5 = 3'd5;
	localparam logic [2:0]          FN_UNUSED6 = 3'd6;
	localparam logic [2:0]          FN_UNUSED7 = 3'd7;
	localparam logic [IDX_BITS-1:0] REG_NONE   = 3'd7;

	class segment_scoreboard;
		int unsigned eps;
		longint      bed[6];
		longint      box[6];
		longint      pos[NUM_AXES];
		longint      ofs[NUM_AXES];
		bit          rel;
		res_t        expected_q[$];
		int          errors;
		string       axis_tag[3] = '{"x", "y", "z"};

		function new();
			eps = EPS_RESET;
			for (int k = 0; k < 3; k++) begin
				bed[2*k]   = BED_MIN_RESET;
				bed[2*k+1] = BED_MAX_RESET;
			end
			for (int k = 0; k < 6; k++) begin
				box[k] = bed[k ^ 1];
			end
			for (int a = 0; a < NUM_AXES; a++) begin
				pos[a] = 0;
				ofs[a] = 0;
			end
			rel    = 1'b0;
			errors = 0;
		endfunction

		static function longint clamp(longint v);
			if (v > longint'(C_MAX)) begin
				return longint'(C_MAX);
			end
			if (v < longint'(C_MIN)) begin
				return longint'(C_MIN);
			end
			return v;
		endfunction

		function void write_reg(logic [IDX_BITS-1:0] idx, logic [COORD_BITS-1:0] data);
			int k;
			if (idx == REG_EPS) begin
				eps = data[EPS_BITS-1:0];
			end else if (idx >= REG_BED_XMIN && idx <= REG_BED_ZMAX) begin
				k          = int'(idx) - int'(REG_BED_XMIN);
				bed[k]     = longint'(coord_t'(data));
				box[k ^ 1] = bed[k];
			end
		endfunction

		function bit box_inside();
			for (int a = 0; a < 3; a++) begin
				if (!(box[2*a] < bed[2*a+1]) || !(box[2*a+1] > bed[2*a])) begin
					return 1'b0;
				end
			end
			return 1'b1;
		endfunction

		function void note_cmd(cmd_t c);
			res_t   r;
			longint v[NUM_AXES];
			longint nxt[NUM_AXES];
			longint d;
			bit     moved;
			r     = '0;
			moved = 1'b0;
			for (int a = 0; a < NUM_AXES; a++) begin
				v[a] = longint'(c.val[a]);
			end
			case (c.func)
				FN_MOVE: begin
					for (int a = 0; a < NUM_AXES; a++) begin
						if (c.axis_mask[a]) begin
							nxt[a] = rel ? clamp(v[a] + pos[a]) : v[a];
						end else begin
							nxt[a] = pos[a];
						end
					end
					for (int a = 0; a < 3; a++) begin
						d = nxt[a] - pos[a];
						if (d < 0) begin
							d = -d;
						end
						if (d >= longint'(eps)) begin
							moved = 1'b1;
						end
					end
					if (moved && nxt[AX_E] - pos[AX_E] > longint'(eps)) begin
						r.emitted = 1'b1;
						for (int a = 0; a < 3; a++) begin
							if (nxt[a] >= bed[2*a] && nxt[a] < box[2*a]) begin
								box[2*a] = nxt[a];
							end
							if (nxt[a] <= bed[2*a+1] && nxt[a] > box[2*a+1]) begin
								box[2*a+1] = nxt[a];
							end
							r.seg_start[a] = coord_t'(clamp(nxt[a] + ofs[a]));
							r.seg_end[a]   = coord_t'(clamp(pos[a] + ofs[a]));
						end
					end
					pos = nxt;
				end
				FN_ABS: begin
					rel = 1'b0;
				end
				FN_REL: begin
					rel = 1'b1;
				end
				FN_SETPOS: begin
					for (int a = 0; a < NUM_AXES; a++) begin
						if (c.axis_mask[a]) begin
							ofs[a] = clamp(ofs[a] + pos[a] - v[a]);
							pos[a] = v[a];
						end
					end
				end
				FN_QUERY: begin
					for (int a = 0; a < 3; a++) begin
						r.seg_start[a] = coord_t'(box[2*a]);
						r.seg_end[a]   = coord_t'(box[2*a+1]);
					end
				end
				default: begin
				end
			endcase
			r.box_valid = box_inside();
			expected_q.push_back(r);
		endfunction

		function void compare(string name, logic signed [63:0] want, logic signed [63:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_q.size() == 0) begin
				$error("result transaction with no command outstanding");
				errors++;
				return;
			end
			want = expected_q.pop_front();
			compare("emitted", want.emitted, got.emitted);
			for (int a = 0; a < 3; a++) begin
				compare({"start_", axis_tag[a]}, want.seg_start[a], got.seg_start[a]);
				compare({"end_", axis_tag[a]}, want.seg_end[a], got.seg_end[a]);
			end
			compare("box_valid", want.box_valid, got.box_valid);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  wr_en;
	logic [IDX_BITS-1:0]   wr_index;
	logic [COORD_BITS-1:0] wr_data;
	bit                    long_hold_req;

	segment_scoreboard sb = new();

	gmst_cmd_if cmd_ch();
	gmst_res_if res_ch();

	gcode_move_segment_tracker i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_ch),
		.res      (res_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("gcode_move_segment_tracker verification failed");
		$finish;
	end

	always @(posedge clk) begin
		cmd_t c;
		res_t r;
		if (arst_n && cmd_ch.valid && cmd_ch.ready) begin
			c.func          = cmd_ch.func;
			c.axis_mask     = cmd_ch.axis_mask;
			c.val[AX_X]     = cmd_ch.val_x;
			c.val[AX_Y]     = cmd_ch.val_y;
			c.val[AX_Z]     = cmd_ch.val_z;
			c.val[AX_E]     = cmd_ch.val_e;
			sb.note_cmd(c);
		end
		if (arst_n && res_ch.valid && res_ch.ready) begin
			r.emitted         = res_ch.emitted;
			r.seg_start[AX_X] = res_ch.start_x;
			r.seg_start[AX_Y] = res_ch.start_y;
			r.seg_start[AX_Z] = res_ch.start_z;
			r.seg_end[AX_X]   = res_ch.end_x;
			r.seg_end[AX_Y]   = res_ch.end_y;
			r.seg_end[AX_Z]   = res_ch.end_z;
			r.box_valid       = res_ch.box_valid;
			sb.check_result(r);
		end
	end

	// result stall pattern, with one long hold-off on request
	initial begin
		int  mode;
		int  span;
		bit  hold_done;
		res_ch.ready = 1'b0;
		hold_done    = 1'b0;
		@(negedge clk);
		forever begin
			if (long_hold_req && !hold_done) begin
				hold_done = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(4, 40);
				repeat (span) begin
					case (mode)
						0: res_ch.ready <= 1'b1;
						1: res_ch.ready <= ($urandom_range(0, 1) == 0);
						2: res_ch.ready <= ($urandom_range(0, 3) != 0);
						default: res_ch.ready <= ($urandom_range(0, 5) == 0);
					endcase
					@(negedge clk);
				end
			end
		end
	end

	task automatic send_cmd(logic [2:0] f, logic [NUM_AXES-1:0] m,
			coord_t x, coord_t y, coord_t z, coord_t e);
		cmd_ch.valid     <= 1'b1;
		cmd_ch.func      <= f;
		cmd_ch.axis_mask <= m;
		cmd_ch.val_x     <= x;
		cmd_ch.val_y     <= y;
		cmd_ch.val_z     <= z;
		cmd_ch.val_e     <= e;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic idle_gap(int n);
		if (n > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic drain();
		cmd_ch.valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [COORD_BITS-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(negedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic program_regs(logic [COORD_BITS-1:0] eps_word,
			coord_t xmin, coord_t xmax, coord_t ymin, coord_t ymax,
			coord_t zmin, coord_t zmax);
		write_reg(REG_EPS, eps_word);
		write_reg(REG_BED_XMIN, xmin);
		write_reg(REG_BED_XMAX, xmax);
		write_reg(REG_BED_YMIN, ymin);
		write_reg(REG_BED_YMAX, ymax);
		write_reg(REG_BED_ZMIN, zmin);
		write_reg(REG_BED_ZMAX, zmax);
	endtask

	function automatic coord_t pick_coord(longint base, int unsigned spread);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 4) begin
			return C_MIN;
		end
		if (roll < 8) begin
			return C_MAX;
		end
		if (roll < 16) begin
			return coord_t'($urandom);
		end
		return coord_t'(segment_scoreboard::clamp(base
			+ longint'($urandom_range(0, 2 * spread)) - longint'(spread)));
	endfunction

	task automatic random_item();
		logic [2:0]          f;
		logic [NUM_AXES-1:0] m;
		coord_t              v[NUM_AXES];
		int unsigned         roll;
		int unsigned         spread;
		longint              base;
		roll   = $urandom_range(0, 99);
		spread = 2 * sb.eps + 3000;
		f      = FN_MOVE;
		if (roll < 12) begin
			f = 3'($urandom);
		end else if (roll < 17) begin
			f = FN_ABS;
		end else if (roll < 22) begin
			f = FN_REL;
		end else if (roll < 29) begin
			f = FN_SETPOS;
		end else if (roll < 36) begin
			f = FN_QUERY;
		end
		m = 4'($urandom_range(0, 15));
		if (roll < 12) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				v[a] = coord_t'($urandom);
			end
		end else begin
			if (f == FN_MOVE && $urandom_range(0, 3) != 0) begin
				m[AX_E] = 1'b1;
			end
			for (int a = 0; a < NUM_AXES; a++) begin
				base = (sb.rel && f == FN_MOVE) ? 0 : sb.pos[a];
				if (a == AX_E && f == FN_MOVE) begin
					v[a] = coord_t'(segment_scoreboard::clamp(base
						+ longint'($urandom_range(0, spread)) - longint'(spread / 8)));
				end else begin
					v[a] = pick_coord(base, spread);
				end
			end
		end
		send_cmd(f, m, v[AX_X], v[AX_Y], v[AX_Z], v[AX_E]);
	endtask

	task automatic random_block(int n);
		int burst;
		burst = 0;
		repeat (n) begin
			if (burst == 0) begin
				burst = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 24);
				idle_gap(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8));
			end
			random_item();
			burst--;
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		wr_en            = 1'b0;
		wr_index         = '0;
		wr_data          = '0;
		long_hold_req    = 1'b0;
		cmd_ch.valid     = 1'b0;
		cmd_ch.func      = FN_MOVE;
		cmd_ch.axis_mask = '0;
		cmd_ch.val_x     = '0;
		cmd_ch.val_y     = '0;
		cmd_ch.val_z     = '0;
		cmd_ch.val_e     = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: inverted box, threshold of one micrometre
		send_cmd(FN_QUERY, 4'h0, 0, 0, 0, 0);
		send_cmd(FN_MOVE, 4'hF, 1000, 2000, 300, 100);
		send_cmd(FN_MOVE, 4'hF, 1001, 2000, 300, 101);
		send_cmd(FN_MOVE, 4'hF, 1001, 2000, 301, 103);
		send_cmd(FN_MOVE, 4'hF, 1001, 2000, 301, 600);
		send_cmd(FN_MOVE, 4'h1, 5000, 0, 0, 0);
		send_cmd(FN_MOVE, 4'hF, C_MAX, C_MIN, 199999, C_MAX);
		send_cmd(FN_QUERY, 4'hF, C_MIN, C_MAX, C_MIN, C_MAX);
		send_cmd(FN_REL, 4'h0, 0, 0, 0, 0);
		send_cmd(FN_MOVE, 4'hF, C_MAX, C_MIN, 1, 1);
		send_cmd(FN_SETPOS, 4'hF, C_MIN, C_MAX, 0, 0);
		send_cmd(FN_MOVE, 4'hF, 10, 10, 10, 10);
		send_cmd(FN_SETPOS, 4'h5, 0, 7, 0, 7);
		send_cmd(FN_ABS, 4'hF, 1, 1, 1, 1);
		send_cmd(FN_MOVE, 4'h8, 0, 0, 0, C_MAX);
		send_cmd(FN_MOVE, 4'h0, 5, 5, 5, 5);
		send_cmd(FN_MOVE, 4'hF, 3, 3, 3, -32'sd5);
		send_cmd(FN_UNUSED5, 4'hF, C_MAX, C_MAX, C_MAX, C_MAX);
		send_cmd(FN_UNUSED6, 4'hA, C_MIN, 12345, C_MIN, -32'sd1);
		send_cmd(FN_UNUSED7, 4'h5, -32'sd1, C_MIN, 0, C_MAX);
		send_cmd(FN_MOVE, 4'hF, 150000, 150000, 100, 2000);
		send_cmd(FN_MOVE, 4'hF, -32'sd1, 200001, 200000, 4000);
		send_cmd(FN_QUERY, 4'h0, 0, 0, 0, 0);
		drain();

		program_regs(32'd0, -32'sd1000, 50000, -32'sd1000, 50000, 0, 30000);
		long_hold_req = 1'b1;
		random_block(140);
		drain();

		program_regs(32'd65535, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX);
		random_block(140);
		drain();

		// upper half of the word must be dropped for the threshold
		program_regs(32'hFFFF_0003, 100000, -32'sd100000, 5000, 5000, C_MAX, C_MIN);
		write_reg(REG_NONE, $urandom);
		random_block(140);
		drain();

		program_regs($urandom_range(1, 200),
			-coord_t'($urandom_range(0, 50000)), $urandom_range(1000, 300000),
			-coord_t'($urandom_range(0, 50000)), $urandom_range(1000, 300000),
			-coord_t'($urandom_range(0, 5000)), $urandom_range(1000, 100000));
		random_block(140);
		drain();

		program_regs(EPS_RESET, BED_MIN_RESET, BED_MAX_RESET, BED_MIN_RESET,
			BED_MAX_RESET, BED_MIN_RESET, BED_MAX_RESET);
		random_block(140);
		drain();

		if (sb.errors == 0) begin
			$display("gcode_move_segment_tracker verification clean");
		end else begin
			$display("gcode_move_segment_tracker verification failed");
		end
		$finish;
	end

endmodule
